// ===== src/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked out of reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never hold
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");

`endif

// ===== src/zru_pkg.sv =====
package zru_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IN_RATE_W  = 17;
  localparam int OUT_RATE_W = 18;
  localparam int GAIN_W     = 4;
  localparam int PHASE_W    = 17;
  localparam int ACC_W      = 19;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int MAX_EMIT   = 8;
  localparam int EMIT_W     = $clog2(MAX_EMIT + 1);
  localparam int CHUNK_DEF  = 256;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [IN_RATE_W-1:0]  IN_RATE_RST  = IN_RATE_W'(16000);
  localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST = OUT_RATE_W'(44100);
  localparam logic [GAIN_W-1:0]     GAIN_RST     = GAIN_W'(3);

  typedef enum logic [1:0] {
    REG_IN_RATE  = 2'd0,
    REG_OUT_RATE = 2'd1,
    REG_GAIN     = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic last_emit;
    logic finish;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic ge1;
    logic ge2;
    logic blk;
    logic fill_zero;
    logic can_load;
  } status_t;

endpackage

// ===== src/zru_regs.sv =====
module zru_regs
  import zru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output logic [IN_RATE_W-1:0]  in_rate,
  output logic [OUT_RATE_W-1:0] out_rate,
  output logic [GAIN_W-1:0]     gain
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rate  <= IN_RATE_RST;
      out_rate <= OUT_RATE_RST;
      gain     <= GAIN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_IN_RATE:  in_rate  <= pwdata[IN_RATE_W-1:0];
        REG_OUT_RATE: out_rate <= pwdata[OUT_RATE_W-1:0];
        REG_GAIN:     gain     <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IN_RATE:  prdata = DATA_W'(in_rate);
      REG_OUT_RATE: prdata = DATA_W'(out_rate);
      REG_GAIN:     prdata = DATA_W'(gain);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== src/zru_ctrl.sv =====
module zru_ctrl
  import zru_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EMIT  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [EMIT_W-1:0] n, n_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    n_next     = n;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          n_next     = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.ge1 && (n < EMIT_W'(MAX_EMIT))) begin
          if (st.can_load) begin
            cmd.emit      = 1'b1;
            cmd.last_emit = !st.ge2 || (n == EMIT_W'(MAX_EMIT - 1));
            n_next        = n + EMIT_W'(1);
          end
        end else begin
          cmd.finish = 1'b1;
          state_next = (st.blk && !st.fill_zero) ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (st.can_load) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

endmodule

// ===== src/zru_dp.sv =====
`include "assert_macros.svh"

module zru_dp
  import zru_pkg::*;
#(
  parameter int CHUNK = CHUNK_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    st,
  input  logic [IN_RATE_W-1:0]       in_rate,
  input  logic [OUT_RATE_W-1:0]      out_rate,
  input  logic [GAIN_W-1:0]          gain,
  input  logic signed [SAMPLE_W-1:0] pcm_sample,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       sample_valid,
  output logic                       chunk_end
);

  localparam int FILL_W = (CHUNK > 1) ? $clog2(CHUNK) : 1;
  localparam logic [FILL_W:0] CHUNK_V = (FILL_W + 1)'(CHUNK);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

  logic [ACC_W-1:0]           acc;
  logic [FILL_W-1:0]          fill;
  logic signed [SAMPLE_W-1:0] held;
  logic                       blk;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] sat;
  logic [FILL_W:0]            fill_inc;
  logic                       wrap;
  logic                       close;
  logic [ACC_W-1:0]           rate1;
  logic [ACC_W-1:0]           rate2;

  assign prod = pcm_sample * $signed({1'b0, gain});

  always_comb begin
    priority if (prod > SAT_HI) sat = SAT_HI[SAMPLE_W-1:0];
    else if (prod < SAT_LO)     sat = SAT_LO[SAMPLE_W-1:0];
    else                        sat = prod[SAMPLE_W-1:0];
  end

  assign rate1    = ACC_W'(in_rate);
  assign rate2    = {1'b0, in_rate, 1'b0};
  assign fill_inc = {1'b0, fill} + (FILL_W + 1)'(1);
  assign wrap     = (fill_inc == CHUNK_V);
  assign close    = wrap || (blk && cmd.last_emit);

  assign st.ge1       = (acc >= rate1);
  assign st.ge2       = (acc >= rate2);
  assign st.blk       = blk;
  assign st.fill_zero = (fill == '0);
  assign st.can_load  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      fill <= '0;
    end else begin
      if (cmd.load) begin
        acc <= ACC_W'(acc[PHASE_W-1:0]) + ACC_W'(out_rate);
      end else if (cmd.emit) begin
        acc <= acc - rate1;
      end else if (cmd.finish && st.ge1) begin
        acc <= '0;
      end
      if (cmd.emit) begin
        fill <= close ? '0 : fill_inc[FILL_W-1:0];
      end else if (cmd.flush) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held <= sat;
      blk  <= block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample   <= held;
      sample_valid <= 1'b1;
      chunk_end    <= close;
    end else if (cmd.flush) begin
      out_sample   <= '0;
      sample_valid <= 1'b0;
      chunk_end    <= 1'b1;
    end
  end

  `ASSERT_NEVER(a_one_source, clk, rst, cmd.emit && cmd.flush)
  `ASSERT_PROP(a_emit_room, clk, rst, cmd.emit |-> st.can_load)
  `ASSERT_PROP(a_flush_clears, clk, rst, cmd.flush |=> (fill == '0))
  `ASSERT_PROP(a_phase_fits, clk, rst, cmd.finish |=> (acc[ACC_W-1:PHASE_W] == '0))

endmodule

// ===== src/zoh_rate_upconverter_with_gain_top.sv =====
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  pcm_sample, block_end
// out      output     out_valid/out_stall  out_sample, sample_valid, chunk_end
// cfg      input      APB, pready tied 1   in_rate @0x0, out_rate @0x4, gain @0x8
// An item yields n samples (n at most 8), plus a chunk_end marker for a block end
// that leaves a chunk partly filled; the loop issues one sample per cycle unless stalled.
// Synchronous reset restores the default rates and gain and clears phase and fill.
// A stalled output holds its result; the loop waits while the output register is full and stalled.
module zoh_rate_upconverter_with_gain_top
  import zru_pkg::*;
#(
  parameter int CHUNK = CHUNK_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] pcm_sample,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       sample_valid,
  output logic                       chunk_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [IN_RATE_W-1:0]  in_rate;
  logic [OUT_RATE_W-1:0] out_rate;
  logic [GAIN_W-1:0]     gain;
  cmd_t                  cmd;
  status_t               st;

  zru_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_rate  (in_rate),
    .out_rate (out_rate),
    .gain     (gain)
  );

  zru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  zru_dp #(
    .CHUNK (CHUNK)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_rate      (in_rate),
    .out_rate     (out_rate),
    .gain         (gain),
    .pcm_sample   (pcm_sample),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .sample_valid (sample_valid),
    .chunk_end    (chunk_end)
  );

endmodule
